@@ src/gcm_pkg.sv @@
// ============================================================================
// gcm_pkg
// Shared types and constants of the greedy coin change maker.
// ============================================================================
`default_nettype none

package gcm_pkg;

    // number of denomination registers
    localparam int SLOTS      = 8;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CFG_IDX_W  = 4;
    localparam int VALUE_W    = 16;

    // parameter defaults
    localparam int DEF_NUM_DENOMINATIONS = 8;
    localparam int DEF_MAX_COINS         = 64;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sort_step;
        logic take;
        logic advance;
        logic set_cut;
        logic emit_final;
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sort_done;
        logic fit;
        logic cap_hit;
        logic slot_last;
        logic hold_valid;
        logic out_free;
    } t_ctrl_sts;

endpackage

`default_nettype wire

@@ src/gcm_ctrl.sv @@
// ============================================================================
// gcm_ctrl
// Controller: sequences load, ordering, greedy search and the final result.
// ============================================================================
`default_nettype none

module gcm_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire gcm_pkg::t_ctrl_sts i_sts,
    output gcm_pkg::t_ctrl_cmd      o_cmd,
    output logic                    o_idle
);

    gcm_pkg::t_state r_state;
    gcm_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcm_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = gcm_pkg::ST_SORT;
            end
            gcm_pkg::ST_SORT: begin
                if (i_sts.sort_done) n_state = gcm_pkg::ST_SEARCH;
            end
            gcm_pkg::ST_SEARCH: begin
                if (i_sts.fit && i_sts.cap_hit) begin
                    n_state = gcm_pkg::ST_FINISH;
                end else if (!i_sts.fit && i_sts.slot_last) begin
                    n_state = gcm_pkg::ST_FINISH;
                end
            end
            gcm_pkg::ST_FINISH: begin
                if (i_sts.out_free) n_state = gcm_pkg::ST_IDLE;
            end
            default: n_state = gcm_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd  = '0;
        o_idle = 1'b0;
        case (r_state)
            gcm_pkg::ST_IDLE: begin
                o_idle     = 1'b1;
                o_cmd.load = i_in_valid;
            end
            gcm_pkg::ST_SORT: begin
                o_cmd.sort_step = 1'b1;
            end
            gcm_pkg::ST_SEARCH: begin
                o_cmd.take    = i_sts.fit && !i_sts.cap_hit &&
                                (!i_sts.hold_valid || i_sts.out_free);
                o_cmd.set_cut = i_sts.fit && i_sts.cap_hit;
                o_cmd.advance = !i_sts.fit && !i_sts.slot_last;
            end
            gcm_pkg::ST_FINISH: begin
                o_cmd.emit_final = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/gcm_datapath.sv @@
// ============================================================================
// gcm_datapath
// Datapath: denomination registers, sorting network step, greedy search
// registers, one-coin lookahead hold and the output register.
// ============================================================================
`default_nettype none

module gcm_datapath #(
    parameter int NUM_DENOMINATIONS = gcm_pkg::DEF_NUM_DENOMINATIONS,
    parameter int MAX_COINS         = gcm_pkg::DEF_MAX_COINS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_valid,
    input  wire logic [gcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [gcm_pkg::VALUE_W-1:0]     i_cfg_data,
    // input item
    input  wire logic [gcm_pkg::VALUE_W-1:0]     i_amount,
    // control
    input  wire gcm_pkg::t_ctrl_cmd              i_cmd,
    output gcm_pkg::t_ctrl_sts                   o_sts,
    // result
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic [gcm_pkg::VALUE_W-1:0]          o_coin_value,
    output logic                                 o_no_coin,
    output logic                                 o_truncated,
    output logic                                 o_last
);

    localparam int CNT_W = $clog2(MAX_COINS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COINS);
    localparam logic [gcm_pkg::SLOT_W-1:0] LAST_SLOT = gcm_pkg::SLOT_W'(gcm_pkg::SLOTS - 1);

    logic [gcm_pkg::VALUE_W-1:0] r_den [gcm_pkg::SLOTS];
    logic [gcm_pkg::VALUE_W-1:0] r_sorted [gcm_pkg::SLOTS];
    logic [gcm_pkg::VALUE_W-1:0] n_sorted [gcm_pkg::SLOTS];
    logic [gcm_pkg::SLOT_W-1:0]  r_phase;
    logic [gcm_pkg::SLOT_W-1:0]  r_slot;
    logic [gcm_pkg::VALUE_W-1:0] r_remaining;
    logic [CNT_W-1:0]            r_count;
    logic                        r_cut;
    logic                        r_hold_valid;
    logic [gcm_pkg::VALUE_W-1:0] r_hold_value;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [gcm_pkg::VALUE_W-1:0] r_out_value;
    logic                        r_out_no_coin;
    logic                        r_out_trunc;
    logic                        r_out_last;
    logic [gcm_pkg::VALUE_W-1:0] cur_value;
    logic                        out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gcm_pkg::SLOTS; i++) begin
                r_den[i] <= '0;
            end
        end else if (i_cfg_valid &&
                     (i_cfg_index < gcm_pkg::CFG_IDX_W'(gcm_pkg::SLOTS))) begin
            r_den[i_cfg_index[gcm_pkg::SLOT_W-1:0]] <= i_cfg_data;
        end
    end

    // load or one odd-even transposition phase, largest first
    always_comb begin
        n_sorted = r_sorted;
        if (i_cmd.load) begin
            for (int i = 0; i < gcm_pkg::SLOTS; i++) begin
                n_sorted[i] = (i < NUM_DENOMINATIONS) ? r_den[i] : '0;
            end
        end else if (i_cmd.sort_step) begin
            for (int i = 0; i < gcm_pkg::SLOTS - 1; i++) begin
                if (((i % 2) == 0) == !r_phase[0] && r_sorted[i] < r_sorted[i+1]) begin
                    n_sorted[i]   = r_sorted[i+1];
                    n_sorted[i+1] = r_sorted[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sorted <= n_sorted;
    end

    // greedy search state
    assign cur_value = r_sorted[r_slot];
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_phase     <= '0;
            r_slot      <= '0;
            r_remaining <= i_amount;
            r_count     <= '0;
            r_cut       <= 1'b0;
        end else begin
            if (i_cmd.sort_step) r_phase <= r_phase + 1'b1;
            if (i_cmd.advance) r_slot <= r_slot + 1'b1;
            if (i_cmd.take) begin
                r_remaining <= r_remaining - cur_value;
                r_count     <= r_count + 1'b1;
            end
            if (i_cmd.set_cut) r_cut <= 1'b1;
        end
    end

    // lookahead hold: a coin waits here until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_hold_valid <= 1'b0;
        end else if (i_cmd.take) begin
            r_hold_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_hold_value <= cur_value;
    end

    // output register
    always_comb begin
        if ((i_cmd.take && r_hold_valid) || i_cmd.emit_final) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && r_hold_valid) begin
            r_out_value   <= r_hold_value;
            r_out_no_coin <= 1'b0;
            r_out_trunc   <= 1'b0;
            r_out_last    <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_out_value   <= r_hold_valid ? r_hold_value : '0;
            r_out_no_coin <= !r_hold_valid;
            r_out_trunc   <= r_hold_valid && r_cut;
            r_out_last    <= 1'b1;
        end
    end

    // status to controller
    always_comb begin
        o_sts.sort_done  = (r_phase == LAST_SLOT);
        o_sts.fit        = (cur_value != '0) && (cur_value <= r_remaining);
        o_sts.cap_hit    = (r_count == MAX_CNT);
        o_sts.slot_last  = (r_slot == LAST_SLOT);
        o_sts.hold_valid = r_hold_valid;
        o_sts.out_free   = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_coin_value = r_out_value;
    assign o_no_coin    = r_out_no_coin;
    assign o_truncated  = r_out_trunc;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

@@ src/greedy_change_maker.sv @@
// ============================================================================
// greedy_change_maker
// Greedy coin change: hands out coins of up to eight denominations, largest
// first, for each requested amount.
// ============================================================================
// Usage:
//   Configuration: write denomination i at index i over the cfg channel while
//   the block is idle; o_cfg_ready is always high, indexes beyond 7 are ignored.
//   Input: i_amount is taken when i_in_valid is high and o_in_stall is low.
//   o_in_stall is high from the accepting edge until the final result of that
//   amount sits in the output register.
//   Output: one transaction per coin, o_last marks the final one; when no coin
//   fits a single transaction with o_no_coin set is sent, and o_truncated
//   marks a final coin cut off by the coin cap.
//   Sequence: the denominations are ordered with an odd-even transposition
//   network, then the search takes coins and steps through the slots (8 at
//   most), then the final result is emitted and the block returns to idle.
//   Each coin waits in a lookahead hold and reaches the output register when
//   the next coin is taken or with the final result.
//   Stall: i_out_stall holds the output register; the search waits when a
//   second coin is found while the register is still occupied.
//   Reset (i_rst_n low, synchronous): denominations clear to zero, the
//   controller returns to idle and no result is pending.
// ============================================================================
`default_nettype none

module greedy_change_maker #(
    parameter int NUM_DENOMINATIONS = gcm_pkg::DEF_NUM_DENOMINATIONS,
    parameter int MAX_COINS         = gcm_pkg::DEF_MAX_COINS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gcm_pkg::VALUE_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [gcm_pkg::VALUE_W-1:0]   i_amount,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [gcm_pkg::VALUE_W-1:0]        o_coin_value,
    output logic                               o_no_coin,
    output logic                               o_truncated,
    output logic                               o_last
);

    gcm_pkg::t_ctrl_cmd cmd;
    gcm_pkg::t_ctrl_sts sts;
    logic               idle;

    // controller
    gcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    // datapath
    gcm_datapath #(
        .NUM_DENOMINATIONS (NUM_DENOMINATIONS),
        .MAX_COINS         (MAX_COINS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_amount     (i_amount),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_coin_value (o_coin_value),
        .o_no_coin    (o_no_coin),
        .o_truncated  (o_truncated),
        .o_last       (o_last)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !idle;

endmodule

`default_nettype wire

@@ bench/greedy_change_maker_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// greedy_change_maker_tb
// Self-checking bench for the greedy coin change maker. A directed table
// covers empty and extreme denomination sets, the coin cap, duplicate and
// empty slots and amounts that no coin fits. Random phases then reload the
// denominations and send random amounts. Every coin transaction is checked
// against typed rows or the greedy predictor while both sides idle and stall.
// ============================================================================

module greedy_change_maker_tb;

    localparam int SLOTS         = gcm_pkg::SLOTS;
    localparam int SLOT_W        = gcm_pkg::SLOT_W;
    localparam int CFG_IDX_W     = gcm_pkg::CFG_IDX_W;
    localparam int VALUE_W       = gcm_pkg::VALUE_W;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 5;
    localparam int COIN_CAP      = gcm_pkg::DEF_MAX_COINS;
    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;

    // register map: denomination slot i sits at index i
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_0     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_1     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_2     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_3     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_4     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_5     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_6     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_7     = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

    typedef struct packed {
        logic [VALUE_W-1:0] coin_value;
        logic               no_coin;
        logic               truncated;
        logic               last;
    } t_coin;

    localparam t_coin NONE_FITS = '{coin_value: '0, no_coin: 1'b1,
                                    truncated: 1'b0, last: 1'b1};

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_AMOUNT,
        STEP_TYPED
    } t_step_kind;

    typedef struct {
        t_step_kind             kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [VALUE_W-1:0]     value;
        t_coin                  coin;
    } t_step;

    typedef enum logic [2:0] {
        MIX_COMMON,
        MIX_SPARSE,
        MIX_WIDE,
        MIX_REPEATS,
        MIX_EMPTY
    } t_mix;

    typedef enum logic [1:0] {
        SEG_FREE,
        SEG_CHOPPY,
        SEG_BLOCKED
    } t_seg;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [VALUE_W-1:0]     i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic [VALUE_W-1:0]     i_amount    = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [VALUE_W-1:0]     o_coin_value;
    logic                   o_no_coin;
    logic                   o_truncated;
    logic                   o_last;

    // predictor state and expected coins in order
    logic [VALUE_W-1:0]     denom_shadow [SLOTS];
    t_coin                  coins_owed [$];
    t_step                  directed_steps [$];
    int                     mismatches   = 0;
    int                     cycle_count  = 0;
    bit                     hold_request = 1'b0;

    greedy_change_maker DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_amount     (i_amount),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_coin_value (o_coin_value),
        .o_no_coin    (o_no_coin),
        .o_truncated  (o_truncated),
        .o_last       (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // greedy change for one amount, appended to the expected coins
    function automatic void make_change(input logic [VALUE_W-1:0] amount);
        logic [VALUE_W-1:0] order [SLOTS];
        logic [VALUE_W-1:0] key;
        logic [VALUE_W-1:0] left;
        t_coin              batch [$];
        t_coin              coin;
        int                 i;
        int                 j;
        bit                 cut;
        for (i = 0; i < SLOTS; i++) order[i] = denom_shadow[i];
        // descending insertion sort
        for (i = 1; i < SLOTS; i++) begin
            key = order[i];
            j = i - 1;
            while (j >= 0 && order[j] < key) begin
                order[j + 1] = order[j];
                j--;
            end
            order[j + 1] = key;
        end
        left = amount;
        cut  = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
            // empty slot, would never stop
            if (order[i] == '0) continue;
            while (order[i] <= left) begin
                if (batch.size() >= COIN_CAP) begin
                    cut = 1'b1;
                    break;
                end
                coin = '{coin_value: order[i], no_coin: 1'b0,
                         truncated: 1'b0, last: 1'b0};
                batch = {batch, coin};
                left = left - order[i];
            end
            if (cut || left == '0) break;
        end
        if (batch.size() == 0) begin
            coins_owed = {coins_owed, NONE_FITS};
        end else begin
            batch[batch.size() - 1].truncated = cut;
            batch[batch.size() - 1].last      = 1'b1;
            coins_owed = {coins_owed, batch};
        end
    endfunction

    function automatic t_coin single_coin(input logic [VALUE_W-1:0] value);
        return '{coin_value: value, no_coin: 1'b0, truncated: 1'b0, last: 1'b1};
    endfunction

    function automatic t_step write_row(input logic [CFG_IDX_W-1:0] index,
                                        input logic [VALUE_W-1:0] value);
        return '{kind: STEP_WRITE, index: index, value: value, coin: NONE_FITS};
    endfunction

    function automatic t_step amount_row(input logic [VALUE_W-1:0] amount);
        return '{kind: STEP_AMOUNT, index: '0, value: amount, coin: NONE_FITS};
    endfunction

    function automatic t_step typed_row(input logic [VALUE_W-1:0] amount,
                                        input t_coin coin);
        return '{kind: STEP_TYPED, index: '0, value: amount, coin: coin};
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_amount();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return VALUE_W'($urandom_range(0, 65535));
            default: return VALUE_W'($urandom_range(0, 1500));
        endcase
    endfunction

    // wait until every expected coin has arrived and the block has settled
    task automatic wait_idle();
        while (coins_owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write transaction, valid left high for the next one
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [VALUE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index <= REG_DENOM_7) denom_shadow[index[SLOT_W-1:0]] = value;
    endtask

    // one amount transaction, expectation recorded at acceptance
    task automatic send_amount(input logic [VALUE_W-1:0] amount, input bit typed,
                               input t_coin typed_coin, input bit with_gaps);
        int gap;
        gap = with_gaps ? sender_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_amount   <= amount;
        do @(posedge i_clk); while (o_in_stall);
        if (typed) coins_owed = {coins_owed, typed_coin};
        else make_change(amount);
    endtask

    // drain, then load a random denomination set
    task automatic reload_denominations(input t_mix mix);
        logic [VALUE_W-1:0] common [10];
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] rep_a;
        logic [VALUE_W-1:0] rep_b;
        int                 k;
        common = '{16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd25, 16'd50,
                   16'd100, 16'd200, 16'd500};
        rep_a = VALUE_W'($urandom_range(1, 300));
        rep_b = VALUE_W'($urandom_range(1, 60));
        i_in_valid <= 1'b0;
        wait_idle();
        for (k = 0; k < SLOTS; k++) begin
            case (mix)
                MIX_COMMON: begin
                    if ($urandom_range(0, 7) == 0) value = '0;
                    else if ($urandom_range(0, 1) == 0) value = common[$urandom_range(0, 9)];
                    else value = VALUE_W'($urandom_range(1, 500));
                end
                MIX_SPARSE: begin
                    value = ($urandom_range(0, 3) == 0) ?
                            VALUE_W'($urandom_range(1, 65535)) : '0;
                end
                MIX_WIDE: value = VALUE_W'($urandom);
                MIX_REPEATS: begin
                    case ($urandom_range(0, 2))
                        0:       value = rep_a;
                        1:       value = rep_b;
                        default: value = '0;
                    endcase
                end
                default: value = '0;
            endcase
            write_register(REG_DENOM_0 + CFG_IDX_W'(k), value);
        end
        // writes beyond the slot list must be ignored
        if ($urandom_range(0, 2) == 0) begin
            write_register(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                           VALUE_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // output stall pattern, with a long hold-off on request
    initial begin : receiver
        int   seg_left;
        int   hold_left;
        t_seg seg;
        seg_left  = 0;
        hold_left = 0;
        seg       = SEG_FREE;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            seg = SEG_FREE;
                            seg_left = $urandom_range(10, 60);
                        end
                        9: begin
                            seg = SEG_BLOCKED;
                            seg_left = $urandom_range(8, 20);
                        end
                        default: begin
                            seg = SEG_CHOPPY;
                            seg_left = $urandom_range(10, 60);
                        end
                    endcase
                end
                seg_left--;
                case (seg)
                    SEG_FREE:    i_out_stall <= 1'b0;
                    SEG_BLOCKED: i_out_stall <= 1'b1;
                    default:     i_out_stall <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    // compare each coin transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_coin want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (coins_owed.size() == 0) begin
                $error("unexpected transaction: coin_value %0d no_coin %0d last %0d",
                       o_coin_value, o_no_coin, o_last);
                mismatches++;
            end else begin
                want = coins_owed.pop_front();
                if (o_coin_value !== want.coin_value) begin
                    $error("coin_value: expected %0d, actual %0d",
                           want.coin_value, o_coin_value);
                    mismatches++;
                end
                if (o_no_coin !== want.no_coin) begin
                    $error("no_coin: expected %0d, actual %0d", want.no_coin, o_no_coin);
                    mismatches++;
                end
                if (o_truncated !== want.truncated) begin
                    $error("truncated: expected %0d, actual %0d",
                           want.truncated, o_truncated);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        bit   last_was_write;
        int   random_sent;
        int   phase;
        int   burst;
        int   n;
        int   r;
        bit   with_gaps;
        t_mix mix;

        foreach (denom_shadow[k]) denom_shadow[k] = '0;

        directed_steps = '{
            // nothing configured after reset
            typed_row(16'd65535, NONE_FITS),
            typed_row(16'd0, NONE_FITS),
            // single one-hundredth coin, coin cap
            write_row(REG_DENOM_0, 16'd1),
            typed_row(16'd1, single_coin(16'd1)),
            amount_row(16'd100),
            typed_row(16'd0, NONE_FITS),
            // largest and smallest coin
            write_row(REG_DENOM_0, 16'd65535),
            write_row(REG_DENOM_7, 16'd1),
            typed_row(16'd65535, single_coin(16'd65535)),
            amount_row(16'd64),
            amount_row(16'd65),
            amount_row(16'd65534),
            // scrambled set with a duplicate and an empty slot
            write_row(REG_DENOM_0, 16'd5),
            write_row(REG_DENOM_1, 16'd200),
            write_row(REG_DENOM_2, 16'd0),
            write_row(REG_DENOM_3, 16'd50),
            write_row(REG_DENOM_4, 16'd100),
            write_row(REG_DENOM_5, 16'd25),
            write_row(REG_DENOM_6, 16'd100),
            write_row(REG_DENOM_7, 16'd10),
            write_row(REG_UNMAPPED_LO, 16'd1),
            write_row(REG_UNMAPPED_HI, 16'd65535),
            amount_row(16'd385),
            typed_row(16'd3, NONE_FITS),
            amount_row(16'd7),
            typed_row(16'd200, single_coin(16'd200)),
            amount_row(16'd12800),
            amount_row(16'd12801),
            amount_row(16'd65535),
            // set where greedy is not optimal
            write_row(REG_DENOM_0, 16'd4),
            write_row(REG_DENOM_1, 16'd3),
            write_row(REG_DENOM_2, 16'd1),
            write_row(REG_DENOM_3, 16'd0),
            write_row(REG_DENOM_4, 16'd0),
            write_row(REG_DENOM_5, 16'd0),
            write_row(REG_DENOM_6, 16'd0),
            write_row(REG_DENOM_7, 16'd0),
            amount_row(16'd6),
            amount_row(16'd65535),
            // every slot empty again
            write_row(REG_DENOM_0, 16'd0),
            write_row(REG_DENOM_1, 16'd0),
            write_row(REG_DENOM_2, 16'd0),
            typed_row(16'd500, NONE_FITS)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        last_was_write = 1'b0;
        foreach (directed_steps[s]) begin
            if (directed_steps[s].kind == STEP_WRITE) begin
                if (!last_was_write) begin
                    i_in_valid <= 1'b0;
                    wait_idle();
                end
                write_register(directed_steps[s].index, directed_steps[s].value);
                last_was_write = 1'b1;
            end else begin
                if (last_was_write) i_cfg_valid <= 1'b0;
                send_amount(directed_steps[s].value, directed_steps[s].kind == STEP_TYPED,
                            directed_steps[s].coin, 1'b1);
                last_was_write = 1'b0;
            end
        end

        // random phases, each with a fresh denomination set
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 4) mix = MIX_COMMON;
            else if (r == 4) mix = MIX_SPARSE;
            else if (r < 7) mix = MIX_WIDE;
            else if (r < 9) mix = MIX_REPEATS;
            else mix = MIX_EMPTY;
            // the first phase always uses a realistic set
            if (phase == 0) mix = MIX_COMMON;
            reload_denominations(mix);
            with_gaps = (phase % 4 != 3);
            // long output hold-off while amounts keep coming
            if (phase == 1) hold_request = 1'b1;
            burst = $urandom_range(6, 16);
            for (n = 0; n < burst && random_sent < RANDOM_ITEMS; n++) begin
                send_amount(pick_amount(), 1'b0, NONE_FITS, with_gaps);
                random_sent++;
            end
            phase++;
        end

        // drain and finish
        i_in_valid <= 1'b0;
        while (coins_owed.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/gcm_pkg.sv
src/gcm_ctrl.sv
src/gcm_datapath.sv
src/greedy_change_maker.sv
bench/greedy_change_maker_tb.sv
